FILE: hw/rtl/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

   localparam int FRAC_BITS   = 24;
   localparam int VALUE_WIDTH = 48;

   localparam int NOISE_W = FRAC_BITS + 1;
   localparam int VAR_W   = VALUE_WIDTH - 1;
   localparam int GAIN_W  = FRAC_BITS + 1;
   localparam int CNT_W   = $clog2(GAIN_W + 1);

   localparam logic [NOISE_W-1:0]     RST_PROCESS_NOISE = NOISE_W'(1678);
   localparam logic [VAR_W-1:0]       RST_MEAS_NOISE    = VAR_W'(167772);
   localparam logic [VALUE_WIDTH-1:0] RST_INIT_EST      = VALUE_WIDTH'(64'd1342177280);
   localparam logic [VAR_W-1:0]       RST_INIT_VAR      = VAR_W'(64'd167772160000);

   localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

   localparam logic [1:0] CSR_PROCESS_NOISE    = 2'd0;
   localparam logic [1:0] CSR_MEAS_NOISE       = 2'd1;
   localparam logic [1:0] CSR_INITIAL_ESTIMATE = 2'd2;
   localparam logic [1:0] CSR_INITIAL_VARIANCE = 2'd3;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] measurement;
      logic                          restart;
   } skf_req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] prior_estimate;
      logic [VAR_W-1:0]              prior_variance;
      logic [GAIN_W-1:0]             gain;
      logic signed [VALUE_WIDTH-1:0] new_estimate;
      logic [VAR_W-1:0]              new_variance;
   } skf_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } skf_step_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } skf_state_type;

endpackage

FILE: hw/rtl/skf_div.sv
`timescale 1ns / 1ps

module skf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  skf_pkg::skf_step_ctl_type         ctl,
   input  logic [skf_pkg::VALUE_WIDTH-1:0]   num,
   input  logic [skf_pkg::VALUE_WIDTH-1:0]   den,
   output logic [skf_pkg::FRAC_BITS-1:0]     quo
);
   import skf_pkg::*;

   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] den_ff;
   logic [FRAC_BITS-1:0]   quo_ff, quo_in;
   logic [VALUE_WIDTH:0]   rem_dbl;
   logic [VALUE_WIDTH:0]   rem_diff;

   // one quotient bit per step: restoring division of a fraction
   always_comb begin
      rem_dbl  = {rem_ff, 1'b0};
      rem_diff = rem_dbl - {1'b0, den_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (ctl.load) begin
         rem_in = num;
         quo_in = '0;
      end else if (ctl.step) begin
         if (rem_dbl >= {1'b0, den_ff}) begin
            rem_in = rem_diff[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_dbl[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff <= '0;
      end else begin
         quo_ff <= quo_in;
      end
      rem_ff <= rem_in;
      if (ctl.load) begin
         den_ff <= den;
      end
   end

   assign quo = quo_ff;

endmodule

FILE: hw/rtl/skf_mul.sv
`timescale 1ns / 1ps

module skf_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  skf_pkg::skf_step_ctl_type         ctl,
   input  logic [skf_pkg::VALUE_WIDTH-1:0]   mcand,
   input  logic [skf_pkg::GAIN_W-1:0]        mplier,
   output logic [skf_pkg::VALUE_WIDTH-1:0]   prod
);
   import skf_pkg::*;

   logic [VALUE_WIDTH-1:0] mcand_ff;
   logic [GAIN_W-1:0]      mplier_ff, mplier_in;
   logic [VALUE_WIDTH:0]   acc_ff, acc_in;
   logic [GAIN_W-1:0]      low_ff, low_in;
   logic [VALUE_WIDTH+1:0] sum;
   logic [VALUE_WIDTH+1:0] rounded;

   // shift-add, multiplier bits LSB first; low_ff collects the product's low bits
   always_comb begin
      sum = {1'b0, acc_ff} + (mplier_ff[0] ? (VALUE_WIDTH+2)'(mcand_ff) : '0);
      acc_in    = acc_ff;
      low_in    = low_ff;
      mplier_in = mplier_ff;
      if (ctl.load) begin
         acc_in    = '0;
         low_in    = '0;
         mplier_in = mplier;
      end else if (ctl.step) begin
         acc_in    = sum[VALUE_WIDTH+1:1];
         low_in    = {sum[0], low_ff[GAIN_W-1:1]};
         mplier_in = {1'b0, mplier_ff[GAIN_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mplier_ff <= '0;
      end else begin
         mplier_ff <= mplier_in;
      end
      acc_ff <= acc_in;
      low_ff <= low_in;
      if (ctl.load) begin
         mcand_ff <= mcand;
      end
   end

   // round to nearest, halves up
   assign rounded = {acc_ff, low_ff[FRAC_BITS]} + (VALUE_WIDTH+2)'(low_ff[FRAC_BITS-1]);
   assign prod    = rounded[VALUE_WIDTH-1:0];

endmodule

FILE: hw/rtl/scalar_kalman_filter.sv
`timescale 1ns / 1ps

// One-dimensional Kalman filter, constant-value model, Q24.24 values.
// req_ channel: one measurement per transfer (valid/stall); restart reloads
// the initial estimate and variance before the step.
// rsp_ channel: one result per measurement, held in an output register.
// csr_ channel: register writes (index, data), always ready; write only
// while the filter is idle. Writes do not touch the running state.
// Each measurement passes through a setup state, 24 divide steps, 25
// shift-add steps and a finish state before its result is registered.
// A new measurement is taken only once the last has passed the serial divider
// and then the two serial multipliers (which run side by side).
// req_stall is high while an item is being worked on. A finished result
// waits in the output register; the next measurement may be taken
// meanwhile, and a further result waits until the receiver drops rsp_stall.
// Reset (synchronous) restores the registers and the state to their
// defaults and empties the output register.
module scalar_kalman_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  skf_pkg::skf_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output skf_pkg::skf_rsp_type              rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [skf_pkg::VALUE_WIDTH-1:0]   csr_data
);
   import skf_pkg::*;

   skf_state_type state_ff, state_in;

   logic [NOISE_W-1:0]     pn_ff;
   logic [VAR_W-1:0]       mn_ff;
   logic [VALUE_WIDTH-1:0] init_est_ff;
   logic [VAR_W-1:0]       init_var_ff;

   logic [VALUE_WIDTH-1:0] est_ff;
   logic [VAR_W-1:0]       var_ff;

   logic [VALUE_WIDTH-1:0] pe_ff, z_ff, mag_ff;
   logic [VAR_W-1:0]       pv_ff;
   logic                   up_ff, one_ff;
   logic [GAIN_W-1:0]      gain_ff;
   logic [CNT_W-1:0]       count_ff;

   logic                   rsp_valid_ff;
   skf_rsp_type            rsp_data_ff;

   logic                   req_xfer, rsp_xfer, csr_write;
   logic                   finish_load;
   skf_step_ctl_type       div_ctl, mul_ctl;

   logic [VALUE_WIDTH-1:0] est_src;
   logic [VAR_W-1:0]       var_src;
   logic [VALUE_WIDTH-1:0] pv_sum;
   logic [VALUE_WIDTH-1:0] den;
   logic                   up_now;
   logic [FRAC_BITS-1:0]   quo;
   logic [GAIN_W-1:0]      gain_now;
   logic [VALUE_WIDTH-1:0] corr, nv_prod;
   logic [VALUE_WIDTH-1:0] ne;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_xfer  = rsp_valid_ff & ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // prior
   assign est_src = req_data.restart ? init_est_ff : est_ff;
   assign var_src = req_data.restart ? init_var_ff : var_ff;
   assign pv_sum  = VALUE_WIDTH'(var_src) + VALUE_WIDTH'(pn_ff);

   assign den    = VALUE_WIDTH'(pv_ff) + VALUE_WIDTH'(mn_ff);
   assign up_now = $signed(z_ff) >= $signed(pe_ff);

   assign gain_now = one_ff ? GAIN_ONE : GAIN_W'(quo);
   assign ne = up_ff ? pe_ff + corr : pe_ff - corr;

   skf_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (VALUE_WIDTH'(pv_ff)),
      .den   (den),
      .quo   (quo)
   );

   skf_mul u_mul_corr (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .mcand  (mag_ff),
      .mplier (gain_now),
      .prod   (corr)
   );

   skf_mul u_mul_var (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .mcand  (VALUE_WIDTH'(pv_ff)),
      .mplier (GAIN_ONE - gain_now),
      .prod   (nv_prod)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (count_ff == '0) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      div_ctl     = '0;
      mul_ctl     = '0;
      finish_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SETUP: begin
            div_ctl.load = 1'b1;
         end
         ST_DIVIDE: begin
            div_ctl.step = (count_ff != '0);
            mul_ctl.load = (count_ff == '0);
         end
         ST_MULTIPLY: begin
            mul_ctl.step = (count_ff != '0);
         end
         ST_FINISH: begin
            finish_load = ~rsp_valid_ff | ~rsp_stall;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         pn_ff        <= RST_PROCESS_NOISE;
         mn_ff        <= RST_MEAS_NOISE;
         init_est_ff  <= RST_INIT_EST;
         init_var_ff  <= RST_INIT_VAR;
         est_ff       <= RST_INIT_EST;
         var_ff       <= RST_INIT_VAR;
      end else begin
         state_ff <= state_in;

         if (finish_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write) begin
            unique case (csr_index)
               CSR_PROCESS_NOISE:    pn_ff       <= csr_data[NOISE_W-1:0];
               CSR_MEAS_NOISE:       mn_ff       <= csr_data[VAR_W-1:0];
               CSR_INITIAL_ESTIMATE: init_est_ff <= csr_data;
               CSR_INITIAL_VARIANCE: init_var_ff <= csr_data[VAR_W-1:0];
               default: begin
               end
            endcase
         end

         if (state_ff == ST_SETUP) begin
            count_ff <= CNT_W'(FRAC_BITS);
         end else if (div_ctl.step || mul_ctl.step) begin
            count_ff <= count_ff - 1'b1;
         end else if (mul_ctl.load) begin
            count_ff <= CNT_W'(GAIN_W);
         end

         if (finish_load) begin
            est_ff <= ne;
            var_ff <= nv_prod[VAR_W-1:0];
         end
      end

      if (req_xfer) begin
         pe_ff <= est_src;
         pv_ff <= pv_sum[VALUE_WIDTH-1] ? VAR_MAX : pv_sum[VAR_W-1:0];
         z_ff  <= req_data.measurement;
      end

      if (state_ff == ST_SETUP) begin
         up_ff  <= up_now;
         mag_ff <= up_now ? z_ff - pe_ff : pe_ff - z_ff;
         one_ff <= (den == '0) || (VALUE_WIDTH'(pv_ff) >= den);
      end

      if (mul_ctl.load) begin
         gain_ff <= gain_now;
      end

      if (finish_load) begin
         rsp_data_ff.prior_estimate <= pe_ff;
         rsp_data_ff.prior_variance <= pv_ff;
         rsp_data_ff.gain           <= gain_ff;
         rsp_data_ff.new_estimate   <= ne;
         rsp_data_ff.new_variance   <= nv_prod[VAR_W-1:0];
      end
   end

endmodule

FILE: dv/tb_scalar_kalman_filter.sv
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;
   import skf_pkg::*;

   localparam int LIMIT_CYCLES  = 800000;
   localparam int HOLD_CYCLES   = 600;
   localparam int PHASE_ITEMS   = 242;
   localparam int RANDOM_PHASES = 8;
   localparam int MAX_PRINTS    = 40;
   localparam logic [VALUE_WIDTH-1:0] EST_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] EST_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   class kalman_scoreboard;
      logic [NOISE_W-1:0]     process_noise;
      logic [VAR_W-1:0]       meas_noise;
      logic [VALUE_WIDTH-1:0] init_estimate;
      logic [VAR_W-1:0]       init_variance;
      logic [VALUE_WIDTH-1:0] estimate;
      logic [VAR_W-1:0]       variance;
      skf_rsp_type            expected_updates[$];
      int                     mismatches;
      int                     updates_checked;
      int                     measurements;
      int                     restarts;

      function new();
         process_noise   = RST_PROCESS_NOISE;
         meas_noise      = RST_MEAS_NOISE;
         init_estimate   = RST_INIT_EST;
         init_variance   = RST_INIT_VAR;
         estimate        = RST_INIT_EST;
         variance        = RST_INIT_VAR;
         mismatches      = 0;
         updates_checked = 0;
         measurements    = 0;
         restarts        = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [VALUE_WIDTH-1:0] value);
         case (index)
            CSR_PROCESS_NOISE:    process_noise = value[NOISE_W-1:0];
            CSR_MEAS_NOISE:       meas_noise    = value[VAR_W-1:0];
            CSR_INITIAL_ESTIMATE: init_estimate = value;
            CSR_INITIAL_VARIANCE: init_variance = value[VAR_W-1:0];
            default: ;
         endcase
      endfunction

      // (a * b + half) >> FRAC_BITS on the full product
      function logic [63:0] scaled_round(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b} + (128'd1 << (FRAC_BITS - 1));
         return p[FRAC_BITS +: 64];
      endfunction

      function int pending();
         return expected_updates.size();
      endfunction

      function void note_measurement(skf_req_type req);
         logic signed [63:0] prior;
         logic signed [63:0] meas;
         logic [63:0]        pv;
         logic [63:0]        den;
         logic [63:0]        corr;
         logic [63:0]        updated;
         logic [63:0]        shrunk;
         logic [127:0]       quot;
         logic [GAIN_W-1:0]  g;
         skf_rsp_type        upd;
         measurements++;
         if (req.restart) begin
            restarts++;
            estimate = init_estimate;
            variance = init_variance;
         end
         prior = {{(64-VALUE_WIDTH){estimate[VALUE_WIDTH-1]}}, estimate};
         meas  = {{(64-VALUE_WIDTH){req.measurement[VALUE_WIDTH-1]}}, req.measurement};
         pv = 64'(variance) + 64'(process_noise);
         if (pv > 64'(VAR_MAX))
            pv = 64'(VAR_MAX);
         den = pv + 64'(meas_noise);
         if (den == 0 || pv >= den) begin
            g = GAIN_ONE;
         end else begin
            quot = ({64'd0, pv} << FRAC_BITS) / {64'd0, den};
            g = quot[GAIN_W-1:0];
         end
         if (meas >= prior) begin
            corr    = scaled_round(meas - prior, 64'(g));
            updated = prior + corr;
         end else begin
            corr    = scaled_round(prior - meas, 64'(g));
            updated = prior - corr;
         end
         shrunk = scaled_round(pv, 64'(GAIN_ONE - g));
         upd.prior_estimate = estimate;
         upd.prior_variance = pv[VAR_W-1:0];
         upd.gain           = g;
         upd.new_estimate   = updated[VALUE_WIDTH-1:0];
         upd.new_variance   = shrunk[VAR_W-1:0];
         estimate = upd.new_estimate;
         variance = upd.new_variance;
         expected_updates.insert(expected_updates.size(), upd);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTS)
            $display("MISMATCH %s", msg);
      endtask

      task check_update(skf_rsp_type got);
         skf_rsp_type want;
         if (expected_updates.size() == 0) begin
            report($sformatf("update with none outstanding: %h", got));
            return;
         end
         want = expected_updates.pop_front();
         updates_checked++;
         if (got.prior_estimate !== want.prior_estimate)
            report($sformatf("update %0d prior_estimate %h, expected %h", updates_checked,
                             got.prior_estimate, want.prior_estimate));
         if (got.prior_variance !== want.prior_variance)
            report($sformatf("update %0d prior_variance %h, expected %h", updates_checked,
                             got.prior_variance, want.prior_variance));
         if (got.gain !== want.gain)
            report($sformatf("update %0d gain %h, expected %h", updates_checked,
                             got.gain, want.gain));
         if (got.new_estimate !== want.new_estimate)
            report($sformatf("update %0d new_estimate %h, expected %h", updates_checked,
                             got.new_estimate, want.new_estimate));
         if (got.new_variance !== want.new_variance)
            report($sformatf("update %0d new_variance %h, expected %h", updates_checked,
                             got.new_variance, want.new_variance));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   skf_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   skf_rsp_type            rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [1:0]             csr_index;
   logic [VALUE_WIDTH-1:0] csr_data;

   bit                     req_idling;
   bit                     rsp_idling;
   bit                     hold_request;
   int                     cycle_count;
   int                     reg_writes;
   int                     settings_used;
   logic [VALUE_WIDTH-1:0] centre;
   kalman_scoreboard       sb;

   scalar_kalman_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall)
            sb.note_measurement(req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_update(rsp_data);
      end
   end

   // result side: short random stall bursts, calm stretches, one long hold-off
   initial begin : rsp_side
      int held;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idling && $urandom_range(0, 63) == 0) begin
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL scalar_kalman_filter");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic skf_req_type make_req(logic [VALUE_WIDTH-1:0] m, logic r);
      skf_req_type item;
      item.measurement = m;
      item.restart     = r;
      return item;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_measurement();
      logic [63:0] raw;
      logic [63:0] offset;
      raw    = rand64();
      offset = rand64() >> $urandom_range(16, 63);
      case ($urandom_range(0, 9))
         0: return raw[VALUE_WIDTH-1:0];
         1: return EST_MAX;
         2: return EST_MIN;
         default: begin
            if ($urandom_range(0, 1))
               return centre + offset[VALUE_WIDTH-1:0];
            else
               return centre - offset[VALUE_WIDTH-1:0];
         end
      endcase
   endfunction

   task automatic send_measurement(skf_req_type item);
      if (req_idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [VALUE_WIDTH-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   // unused upper bits of the write data carry random junk
   task automatic load_settings(logic [NOISE_W-1:0] pn, logic [VAR_W-1:0] mn,
                                logic [VALUE_WIDTH-1:0] est, logic [VAR_W-1:0] init_var);
      logic [63:0] junk;
      junk = rand64();
      write_reg(CSR_PROCESS_NOISE, {junk[VALUE_WIDTH-1:NOISE_W], pn});
      write_reg(CSR_MEAS_NOISE, {junk[0], mn});
      write_reg(CSR_INITIAL_ESTIMATE, est);
      write_reg(CSR_INITIAL_VARIANCE, {junk[1], init_var});
      centre = est;
      settings_used++;
   endtask

   task automatic load_random_settings();
      logic [63:0]            r1;
      logic [63:0]            r2;
      logic [63:0]            r3;
      logic [63:0]            r4;
      logic [NOISE_W-1:0]     pn;
      logic [VAR_W-1:0]       mn;
      logic [VAR_W-1:0]       iv;
      logic [VALUE_WIDTH-1:0] est;
      r1 = rand64();
      r2 = rand64();
      r3 = rand64();
      r4 = rand64();
      case ($urandom_range(0, 5))
         0: pn = '0;
         1: pn = GAIN_ONE;
         2: pn = '1;
         3: pn = NOISE_W'($urandom_range(0, 65535));
         default: pn = r1[NOISE_W-1:0] >> $urandom_range(0, NOISE_W - 1);
      endcase
      case ($urandom_range(0, 7))
         0: mn = '0;
         1: mn = VAR_W'(1);
         2: mn = VAR_MAX;
         default: mn = r2[VAR_W-1:0] >> $urandom_range(0, VAR_W - 1);
      endcase
      case ($urandom_range(0, 3))
         0: est = r3[VALUE_WIDTH-1:0];
         1: est = EST_MAX;
         2: est = EST_MIN;
         default: est = {{(VALUE_WIDTH-32){r3[31]}}, r3[31:0]};
      endcase
      case ($urandom_range(0, 4))
         0: iv = '0;
         1: iv = VAR_MAX;
         default: iv = r4[VAR_W-1:0] >> $urandom_range(0, VAR_W - 1);
      endcase
      load_settings(pn, mn, est, iv);
   endtask

   initial begin
      int phase;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_PROCESS_NOISE;
      csr_data     <= '0;
      req_idling    = 1'b1;
      rsp_idling    = 1'b1;
      hold_request  = 1'b0;
      cycle_count   = 0;
      reg_writes    = 0;
      settings_used = 1;
      centre        = RST_INIT_EST;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // settings out of reset
      send_measurement(make_req(RST_INIT_EST, 1'b0));
      send_measurement(make_req(EST_MAX, 1'b0));
      send_measurement(make_req(EST_MIN, 1'b0));
      send_measurement(make_req('0, 1'b1));
      send_measurement(make_req('1, 1'b0));
      send_measurement(make_req(EST_MIN, 1'b1));
      send_measurement(make_req(EST_MAX, 1'b0));
      // saturated prior variance, zero measurement noise
      wait_for_drain();
      load_settings('1, '0, EST_MAX, VAR_MAX);
      send_measurement(make_req(EST_MIN, 1'b1));
      send_measurement(make_req(VALUE_WIDTH'(12345), 1'b0));
      // zero denominator
      wait_for_drain();
      load_settings('0, '0, EST_MIN, '0);
      send_measurement(make_req(EST_MAX, 1'b1));
      send_measurement(make_req('0, 1'b0));
      // process noise of one, largest measurement noise
      wait_for_drain();
      load_settings(GAIN_ONE, VAR_MAX, '0, VAR_MAX);
      send_measurement(make_req(EST_MAX, 1'b1));
      send_measurement(make_req(EST_MIN, 1'b0));
      send_measurement(make_req(VALUE_WIDTH'(-12345), 1'b0));
      // zero gain
      wait_for_drain();
      load_settings('0, VAR_W'(1), '1, '0);
      send_measurement(make_req(EST_MAX, 1'b1));
      send_measurement(make_req(EST_MIN, 1'b0));

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         if (phase == RANDOM_PHASES - 1) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end
         load_random_settings();
         if (phase == 2)
            hold_request = 1'b1;
         repeat (PHASE_ITEMS)
            send_measurement(make_req(pick_measurement(), $urandom_range(0, 24) == 0));
      end

      wait_for_drain();
      repeat (60) @(posedge clock);
      $display("Covered %0d measurements (%0d restarts) under %0d settings, %0d register writes",
               sb.measurements, sb.restarts, settings_used, reg_writes);
      $display("%0d updates checked, %0d mismatches, incl. saturation, unit/zero gain, hold-off",
               sb.updates_checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("PASS scalar_kalman_filter");
      else
         $display("FAIL scalar_kalman_filter");
      $finish;
   end

endmodule
